/* rtl/core/lpi_pkg.sv */
package lpi_pkg;

    // Field and register widths fixed by the block definition
    localparam int STEP_W     = 6;
    localparam int CAP_W      = 7;
    localparam int DUR_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Parameter defaults
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS = 1'b1;

    // Register reset values
    localparam logic [STEP_W-1:0] STEP_COUNT_RST = 6'd10;
    localparam logic [CAP_W-1:0]  MAX_POINTS_RST = 7'd64;

endpackage

/* rtl/core/lpi_in_if.sv */
interface lpi_in_if #(
    parameter int COORD_BITS = lpi_pkg::COORD_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [COORD_BITS-1:0]     start_x;
    logic signed [COORD_BITS-1:0]     start_y;
    logic signed [COORD_BITS-1:0]     end_x;
    logic signed [COORD_BITS-1:0]     end_y;
    logic        [lpi_pkg::DUR_W-1:0] total_duration_ms;

    modport source (
        output valid, start_x, start_y, end_x, end_y, total_duration_ms,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, end_x, end_y, total_duration_ms,
        output ready
    );
endinterface

/* rtl/core/lpi_out_if.sv */
interface lpi_out_if #(
    parameter int COORD_BITS = lpi_pkg::COORD_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [COORD_BITS-1:0]     point_x;
    logic signed [COORD_BITS-1:0]     point_y;
    logic        [lpi_pkg::DUR_W-1:0] hold_ms;
    logic                             last;

    modport source (
        output valid, point_x, point_y, hold_ms, last,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, hold_ms, last,
        output ready
    );
endinterface

/* rtl/core/lpi_div.sv */
// Restoring divider: one quotient bit per cycle, DIV_W quotient bits per division.
module lpi_div #(
    parameter int DIV_W = lpi_pkg::DUR_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DIV_W-1:0]           i_dividend,
    input  logic [lpi_pkg::STEP_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [DIV_W-1:0]           o_quo,
    output logic [lpi_pkg::STEP_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [DIV_W-1:0]           r_quo;
    logic [lpi_pkg::STEP_W-1:0] r_rem;

    logic [lpi_pkg::STEP_W:0]   n_trial;
    logic                       n_fit;
    logic [lpi_pkg::STEP_W:0]   n_diff;

    assign n_trial = {r_rem, r_quo[DIV_W-1]};
    assign n_fit   = (n_trial >= {1'b0, i_divisor});
    assign n_diff  = n_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                // shift in the next dividend bit, subtract when it fits
                r_rem <= n_fit ? n_diff[lpi_pkg::STEP_W-1:0]
                               : n_trial[lpi_pkg::STEP_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], n_fit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

/* rtl/core/linear_path_interpolator_top.sv */
// A move request runs three divisions in turn on the shared serial divider
// (hold time, then |dx| / steps, then |dy| / steps), DIV_W = max(32, COORD_BITS + 1).
// Then one waypoint word per cycle while the output is taken, min(steps + 1, cap) words.
// A new request is taken only in idle, after the last waypoint word of the previous one is loaded.
// Reset: synchronous, active low; idle, step_count = 10, max_points = 64, no word pending.
module linear_path_interpolator_top #(
    parameter int MAX_POINTS = lpi_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = lpi_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    lpi_in_if.sink                         in_ch,
    lpi_out_if.source                      out_ch,
    input  logic                           i_cfg_we,
    input  logic [lpi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lpi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int STEP_W = lpi_pkg::STEP_W;
    localparam int CAP_W  = lpi_pkg::CAP_W;
    localparam int DUR_W  = lpi_pkg::DUR_W;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int DIV_W  = (DIFF_W > DUR_W) ? DIFF_W : DUR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_HOLD,
        S_DIV_X,
        S_DIV_Y,
        S_EMIT
    } t_state;

    t_state r_state;

    // configuration
    logic [STEP_W-1:0] r_step_count;
    logic [CAP_W-1:0]  r_max_points;

    // per-request operands
    logic signed [COORD_BITS-1:0] r_sx, r_sy;
    logic                         r_neg_x, r_neg_y;
    logic [DIFF_W-1:0]            r_abs_x, r_abs_y;
    logic [STEP_W-1:0]            r_steps;
    logic [CAP_W-1:0]             r_count;
    logic [CAP_W-1:0]             r_idx;
    logic [DUR_W-1:0]             r_hold;

    // running quotient/remainder of |d| * i / steps
    logic [DIFF_W-1:0] r_qdx, r_qdy, r_qx, r_qy;
    logic [STEP_W-1:0] r_rdx, r_rdy, r_rx, r_ry;

    // divider command
    logic              r_div_start;
    logic [DIV_W-1:0]  r_div_arg;
    logic              div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [STEP_W-1:0] div_rem;

    // output word
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [DUR_W-1:0]             r_out_hold;
    logic                         r_last;

    // request decode
    logic signed [DIFF_W-1:0] n_dx, n_dy;
    logic [DIFF_W-1:0]        n_abs_x, n_abs_y;
    logic [STEP_W-1:0]        n_steps;
    logic [CAP_W-1:0]         n_cap, n_span, n_count;

    // waypoint step
    logic [STEP_W:0]       n_rx_sum, n_ry_sum;
    logic                  n_wrap_x, n_wrap_y;
    logic [STEP_W-1:0]     n_rx, n_ry;
    logic [DIFF_W-1:0]     n_qx, n_qy;
    logic [DIFF_W-1:0]     n_px, n_py;
    logic                  n_load;
    logic                  n_is_last;

    assign n_dx    = DIFF_W'(in_ch.end_x) - DIFF_W'(in_ch.start_x);
    assign n_dy    = DIFF_W'(in_ch.end_y) - DIFF_W'(in_ch.start_y);
    assign n_abs_x = n_dx[DIFF_W-1] ? DIFF_W'(-n_dx) : DIFF_W'(n_dx);
    assign n_abs_y = n_dy[DIFF_W-1] ? DIFF_W'(-n_dy) : DIFF_W'(n_dy);
    assign n_steps = (r_step_count == '0) ? STEP_W'(1) : r_step_count;
    assign n_cap   = (r_max_points > CAP_W'(MAX_POINTS)) ? CAP_W'(MAX_POINTS) : r_max_points;
    assign n_span  = CAP_W'({1'b0, n_steps} + 1'b1);
    assign n_count = (n_span > n_cap) ? n_cap : n_span;

    // advance i -> i + 1: remainder stays below 2 * steps, one subtract suffices
    assign n_rx_sum = {1'b0, r_rx} + {1'b0, r_rdx};
    assign n_ry_sum = {1'b0, r_ry} + {1'b0, r_rdy};
    assign n_wrap_x = (n_rx_sum >= {1'b0, r_steps});
    assign n_wrap_y = (n_ry_sum >= {1'b0, r_steps});
    assign n_rx     = n_wrap_x ? STEP_W'(n_rx_sum - {1'b0, r_steps}) : n_rx_sum[STEP_W-1:0];
    assign n_ry     = n_wrap_y ? STEP_W'(n_ry_sum - {1'b0, r_steps}) : n_ry_sum[STEP_W-1:0];
    assign n_qx     = r_qx + r_qdx + DIFF_W'(n_wrap_x);
    assign n_qy     = r_qy + r_qdy + DIFF_W'(n_wrap_y);

    // start + sign(d) * trunc(|d| * i / steps)
    assign n_px = DIFF_W'(r_sx) + (r_neg_x ? DIFF_W'(-r_qx) : r_qx);
    assign n_py = DIFF_W'(r_sy) + (r_neg_y ? DIFF_W'(-r_qy) : r_qy);

    assign n_load    = (r_state == S_EMIT) && (!r_out_valid || out_ch.ready);
    assign n_is_last = (CAP_W'(r_idx + 1'b1) == r_count);

    lpi_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_arg),
        .i_divisor  (r_steps),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step_count <= lpi_pkg::STEP_COUNT_RST;
            r_max_points <= lpi_pkg::MAX_POINTS_RST;
            r_div_start  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_div_start <= 1'b0;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lpi_pkg::CFG_STEP_COUNT: r_step_count <= i_cfg_data[STEP_W-1:0];
                    lpi_pkg::CFG_MAX_POINTS: r_max_points <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_sx        <= in_ch.start_x;
                        r_sy        <= in_ch.start_y;
                        r_neg_x     <= n_dx[DIFF_W-1];
                        r_neg_y     <= n_dy[DIFF_W-1];
                        r_abs_x     <= n_abs_x;
                        r_abs_y     <= n_abs_y;
                        r_steps     <= n_steps;
                        r_count     <= n_count;
                        // hold time first; drop the request if nothing is emitted
                        if (n_count != '0) begin
                            r_div_start <= 1'b1;
                            r_div_arg   <= DIV_W'(in_ch.total_duration_ms);
                            r_state     <= S_DIV_HOLD;
                        end
                    end
                end
                S_DIV_HOLD: begin
                    if (div_done) begin
                        r_hold      <= div_quo[DUR_W-1:0];
                        r_div_start <= 1'b1;
                        r_div_arg   <= DIV_W'(r_abs_x);
                        r_state     <= S_DIV_X;
                    end
                end
                S_DIV_X: begin
                    if (div_done) begin
                        r_qdx       <= div_quo[DIFF_W-1:0];
                        r_rdx       <= div_rem;
                        r_div_start <= 1'b1;
                        r_div_arg   <= DIV_W'(r_abs_y);
                        r_state     <= S_DIV_Y;
                    end
                end
                S_DIV_Y: begin
                    if (div_done) begin
                        r_qdy   <= div_quo[DIFF_W-1:0];
                        r_rdy   <= div_rem;
                        r_qx    <= '0;
                        r_qy    <= '0;
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_idx   <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (n_load) begin
                        r_out_valid <= 1'b1;
                        r_px        <= n_px[COORD_BITS-1:0];
                        r_py        <= n_py[COORD_BITS-1:0];
                        r_out_hold  <= r_hold;
                        r_last      <= n_is_last;
                        r_qx        <= n_qx;
                        r_qy        <= n_qy;
                        r_rx        <= n_rx;
                        r_ry        <= n_ry;
                        r_idx       <= CAP_W'(r_idx + 1'b1);
                        if (n_is_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready     = (r_state == S_IDLE);
    assign out_ch.valid    = r_out_valid;
    assign out_ch.point_x  = r_px;
    assign out_ch.point_y  = r_py;
    assign out_ch.hold_ms  = r_out_hold;
    assign out_ch.last     = r_last;
endmodule
